>>> src/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg - shared types and constants for the day-table range accumulator
// Word layouts, date constants and calendar lookup functions.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int TableDepthDefault = 65536;
   localparam int BaseYear          = 2000;

   localparam int YearW   = 12;
   localparam int MonthW  = 4;
   localparam int DayW    = 5;
   localparam int AmountW = 40;
   localparam int TotalW  = 64;
   localparam int FracExt = 16;
   localparam int DvdW    = AmountW + FracExt;
   localparam int DayNumW = 21;

   // floor(y / 100) == (y * Recip100) >> RecipShift for every 12-bit y
   localparam int Recip100   = 5243;
   localparam int RecipW     = 13;
   localparam int RecipShift = 19;
   localparam int Q100W      = 6;

   localparam int LeapsBase = (BaseYear - 1) / 4 - (BaseYear - 1) / 100 + (BaseYear - 1) / 400;

   localparam logic CmdAdd = 1'b0;
   localparam logic CmdSum = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [YearW-1:0]   from_year;
      logic [MonthW-1:0]  from_month;
      logic [DayW-1:0]    from_day;
      logic [YearW-1:0]   to_year;
      logic [MonthW-1:0]  to_month;
      logic [DayW-1:0]    to_day;
      logic [AmountW-1:0] amount;
   } req_payload_type;

   typedef struct packed {
      logic [TotalW-1:0] range_total;
      logic              range_error;
   } rsp_payload_type;

   // days in month; zero for a month code outside 1..12
   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic lp);
      logic [DayW-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = lp ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the year before the first of month m
   function automatic logic [8:0] month_start(input logic [MonthW-1:0] m, input logic lp);
      logic [8:0] st;
      case (m)
         4'd1:    st = 9'd0;
         4'd2:    st = 9'd31;
         4'd3:    st = 9'd59;
         4'd4:    st = 9'd90;
         4'd5:    st = 9'd120;
         4'd6:    st = 9'd151;
         4'd7:    st = 9'd181;
         4'd8:    st = 9'd212;
         4'd9:    st = 9'd243;
         4'd10:   st = 9'd273;
         4'd11:   st = 9'd304;
         4'd12:   st = 9'd334;
         default: st = 9'd0;
      endcase
      if (lp && m > 4'd2) begin
         st = st + 9'd1;
      end
      return st;
   endfunction

endpackage

>>> src/drs_if.sv
// ----------------------------------------------------------------------------
// drs_if - request and response channels
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface drs_req_if;
   import drs_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface drs_rsp_if;
   import drs_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/date_range_add_range_sum_core.sv
// ----------------------------------------------------------------------------
// date_range_add_range_sum_core - day-table range accumulator
// Keeps a saturating 64-bit accumulator per day from 1 January of the base
// year. An add word spreads its amount evenly over a date range; a sum word
// returns the saturating total of a range.
//
// req_bus takes one command word when ready; ready stays low until the
// response word has been taken on rsp_bus, so one word is in flight at a time.
// A flagged word (bad date or reversed range) goes straight to the response;
// a sum word walks the range; an add word first works out its share with a
// bit-serial divide and then walks the range.
// Date conversion shares one datapath over both dates, through S_CONV1 and
// S_CONV2 for each; the range walk is one table entry per cycle through the
// RAM read port, with each update written back through the write port in the
// cycle after its read. After reset the table is cleared one entry per cycle
// over all TABLE_DEPTH entries, and req_bus ready stays low meanwhile. A
// stalled response is held in place with ready low until rsp_bus ready.
// ----------------------------------------------------------------------------
module date_range_add_range_sum_core #(
   parameter int TABLE_DEPTH = drs_pkg::TableDepthDefault
) (
   input logic       clock,
   input logic       reset,
   drs_req_if.sink   req_bus,
   drs_rsp_if.source rsp_bus
);
   import drs_pkg::*;

   localparam int IdxW  = $clog2(TABLE_DEPTH);
   localparam int CntW  = IdxW + 1;
   localparam int StepW = $clog2(DvdW);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_CONV1 = 9'b000000100,
      S_CONV2 = 9'b000001000,
      S_CHECK = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_WALK  = 9'b001000000,
      S_DRAIN = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [IdxW-1:0]     clr_ff, clr_in;
   req_payload_type     req_q_ff, req_q_in;
   logic                sel_ff, sel_in;
   logic [Q100W-1:0]    q100_ff, q100_in;
   logic [DayNumW-1:0]  yoff365_ff, yoff365_in;
   logic                base_ok_ff, base_ok_in;
   logic [DayNumW-1:0]  na_ff, na_in, nb_ff, nb_in;
   logic                oka_ff, oka_in, okb_ff, okb_in;
   logic [IdxW-1:0]     addr_ff, addr_in, last_ff, last_in, paddr_ff, paddr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in, rem_ff, rem_in;
   logic [DvdW-1:0]     qd_ff, qd_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic                pend_ff, pend_in;
   logic [TotalW-1:0]   total_ff, total_in;
   logic                err_ff, err_in;

   logic                wr_en, rd_en;
   logic [IdxW-1:0]     wr_addr, rd_addr;
   logic [TotalW-1:0]   wr_data, rd_data;

   logic [YearW-1:0]    cur_year, yoff, ym1, hund;
   logic [MonthW-1:0]   cur_month;
   logic [DayW-1:0]     cur_day;
   logic [YearW+RecipW-1:0] prod;
   logic                rz, lp, date_ok;
   logic [Q100W-1:0]    q1;
   logic [DayNumW-1:0]  leaps, dnum;
   logic [CntW:0]       rem_sh;
   logic                ge;

   function automatic logic [TotalW-1:0] sat_add(input logic [TotalW-1:0] a,
                                                 input logic [TotalW-1:0] b);
      logic [TotalW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TotalW] ? {TotalW{1'b1}} : s[TotalW-1:0];
   endfunction

   drs_ram #(.WIDTH(TotalW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // date conversion datapath, shared by both ends of the range
   always_comb begin
      cur_year  = sel_ff ? req_q_ff.to_year  : req_q_ff.from_year;
      cur_month = sel_ff ? req_q_ff.to_month : req_q_ff.from_month;
      cur_day   = sel_ff ? req_q_ff.to_day   : req_q_ff.from_day;
      prod      = {{RecipW{1'b0}}, cur_year} * (YearW+RecipW)'(Recip100);
      yoff      = cur_year - YearW'(BaseYear);
      hund      = YearW'(q100_ff) * YearW'(100);
      rz        = (cur_year == hund);
      lp        = (cur_year[1:0] == 2'b00) && (!rz || q100_ff[1:0] == 2'b00);
      ym1       = cur_year - YearW'(1);
      q1        = q100_ff - Q100W'(rz);
      leaps     = DayNumW'(ym1 >> 2) - DayNumW'(q1) + DayNumW'(q1 >> 2)
                  - DayNumW'(LeapsBase);
      dnum      = yoff365_ff + leaps + DayNumW'(month_start(cur_month, lp))
                  + DayNumW'(cur_day) - DayNumW'(1);
      date_ok   = base_ok_ff && cur_day != '0 && cur_day <= month_len(cur_month, lp)
                  && dnum < DayNumW'(TABLE_DEPTH);
   end

   assign rem_sh = {rem_ff, qd_ff[DvdW-1]};
   assign ge     = rem_sh >= {1'b0, cnt_ff};

   assign req_bus.ready            = (state_ff == S_IDLE);
   assign rsp_bus.valid            = (state_ff == S_OUT);
   assign rsp_bus.data.range_total = total_ff;
   assign rsp_bus.data.range_error = err_ff;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      req_q_in   = req_q_ff;
      sel_in     = sel_ff;
      q100_in    = q100_ff;
      yoff365_in = yoff365_ff;
      base_ok_in = base_ok_ff;
      na_in      = na_ff;
      nb_in      = nb_ff;
      oka_in     = oka_ff;
      okb_in     = okb_ff;
      addr_in    = addr_ff;
      last_in    = last_ff;
      paddr_in   = paddr_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      qd_in      = qd_ff;
      step_in    = step_ff;
      pend_in    = pend_ff;
      total_in   = total_ff;
      err_in     = err_ff;
      wr_en      = 1'b0;
      wr_addr    = paddr_ff;
      wr_data    = sat_add(rd_data, TotalW'(qd_ff));
      rd_en      = 1'b0;
      rd_addr    = addr_ff;

      // retire the entry read in the previous cycle
      if ((state_ff == S_WALK || state_ff == S_DRAIN) && pend_ff) begin
         if (req_q_ff.cmd == CmdAdd) begin
            wr_en = 1'b1;
         end else begin
            total_in = sat_add(total_ff, rd_data);
         end
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == IdxW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + IdxW'(1);
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               req_q_in = req_bus.data;
               sel_in   = 1'b0;
               state_in = S_CONV1;
            end
         end
         S_CONV1: begin
            q100_in    = prod[RecipShift +: Q100W];
            yoff365_in = DayNumW'(yoff) * DayNumW'(365);
            base_ok_in = cur_year >= YearW'(BaseYear);
            state_in   = S_CONV2;
         end
         S_CONV2: begin
            if (!sel_ff) begin
               na_in    = dnum;
               oka_in   = date_ok;
               sel_in   = 1'b1;
               state_in = S_CONV1;
            end else begin
               nb_in    = dnum;
               okb_in   = date_ok;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            err_in   = !(oka_ff && okb_ff) || (na_ff > nb_ff);
            total_in = '0;
            addr_in  = na_ff[IdxW-1:0];
            last_in  = nb_ff[IdxW-1:0];
            cnt_in   = {1'b0, nb_ff[IdxW-1:0]} - {1'b0, na_ff[IdxW-1:0]} + CntW'(1);
            rem_in   = '0;
            qd_in    = {req_q_ff.amount, {FracExt{1'b0}}};
            step_in  = '0;
            pend_in  = 1'b0;
            if (!(oka_ff && okb_ff) || (na_ff > nb_ff)) begin
               state_in = S_OUT;
            end else if (req_q_ff.cmd == CmdAdd) begin
               state_in = S_DIV;
            end else begin
               state_in = S_WALK;
            end
         end
         S_DIV: begin
            rem_in  = ge ? CntW'(rem_sh - {1'b0, cnt_ff}) : rem_sh[CntW-1:0];
            qd_in   = {qd_ff[DvdW-2:0], ge};
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(DvdW - 1)) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            rd_en    = 1'b1;
            pend_in  = 1'b1;
            paddr_in = addr_ff;
            if (addr_ff == last_ff) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + IdxW'(1);
            end
         end
         S_DRAIN: begin
            pend_in  = 1'b0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_q_ff   <= req_q_in;
      sel_ff     <= sel_in;
      q100_ff    <= q100_in;
      yoff365_ff <= yoff365_in;
      base_ok_ff <= base_ok_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      oka_ff     <= oka_in;
      okb_ff     <= okb_in;
      addr_ff    <= addr_in;
      last_ff    <= last_in;
      paddr_ff   <= paddr_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      qd_ff      <= qd_in;
      step_ff    <= step_in;
      pend_ff    <= pend_in;
      total_ff   <= total_in;
      err_ff     <= err_in;
   end
endmodule

>>> src/drs_ram.sv
// ----------------------------------------------------------------------------
// drs_ram - generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> src/drs_core_chk.sv
// ----------------------------------------------------------------------------
// drs_core_chk - port checker for the day-table range accumulator
// Watches the request and response channels; bound to the core.
// ----------------------------------------------------------------------------
module drs_core_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [drs_pkg::TotalW-1:0] rsp_total,
   input logic                      rsp_error
);
   import drs_pkg::*;

   // one word in flight: no new request while a response is offered
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("not busy after request accept");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_total == '0))
      else $error("flagged response carries a total");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_total) && $stable(rsp_error)))
      else $error("stalled response word changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("channels active straight after reset");
endmodule

bind date_range_add_range_sum_core drs_core_chk u_drs_core_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_total (rsp_bus.data.range_total),
   .rsp_error (rsp_bus.data.range_error)
);

>>> tb/drs_cal_pkg.sv
// ----------------------------------------------------------------------------
// drs_cal_pkg - calendar helpers for the day-table testbench
// Gregorian leap-year rule and month lengths, shared by the stimulus and the
// checker.
// ----------------------------------------------------------------------------
package drs_cal_pkg;

   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // zero for a month code outside 1..12
   function automatic int unsigned days_in(int unsigned y, int unsigned m);
      if (m == 0 || m > 12) begin
         return 0;
      end
      if (m == 2) begin
         return is_leap(y) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

endpackage

>>> tb/day_table_checker.sv
// ----------------------------------------------------------------------------
// day_table_checker - response checker for the day-table range accumulator
// Watches both channels, keeps its own copy of the per-day table, works out
// the response for every accepted command word and compares each response
// word field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module day_table_checker #(
   parameter int TableDepth = drs_pkg::TableDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   drs_req_if        req_mon,
   drs_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending
);
   import drs_pkg::*;
   import drs_cal_pkg::*;

   logic [TotalW-1:0] day_total [TableDepth];
   rsp_payload_type   predicted_rsp [$];
   rsp_payload_type   oldest_rsp;
   int                mismatches  = 0;
   int                outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic logic [TotalW-1:0] sat_sum(logic [TotalW-1:0] a, logic [TotalW-1:0] b);
      logic [TotalW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TotalW] ? '1 : s[TotalW-1:0];
   endfunction

   // leap years in 1 .. y-1
   function automatic int unsigned leaps_before(int unsigned y);
      return (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
   endfunction

   function automatic bit day_index(input logic [YearW-1:0] y, input logic [MonthW-1:0] m,
                                    input logic [DayW-1:0] d, output int unsigned idx);
      int unsigned yr;
      int unsigned n;
      idx = 0;
      yr  = y;
      if (yr < BaseYear || m == 0 || m > 12 || d == 0) begin
         return 1'b0;
      end
      if (d > days_in(yr, m)) begin
         return 1'b0;
      end
      n = 365 * (yr - BaseYear) + leaps_before(yr) - leaps_before(BaseYear);
      for (int unsigned i = 1; i < m; i++) begin
         n += days_in(yr, i);
      end
      n += d - 1;
      if (n >= TableDepth) begin
         return 1'b0;
      end
      idx = n;
      return 1'b1;
   endfunction

   task automatic predict_range_result(input req_payload_type w);
      int unsigned       first;
      int unsigned       last;
      bit                first_ok;
      bit                last_ok;
      logic [TotalW-1:0] share;
      logic [TotalW-1:0] total;
      rsp_payload_type   r;
      first_ok = day_index(w.from_year, w.from_month, w.from_day, first);
      last_ok  = day_index(w.to_year, w.to_month, w.to_day, last);
      r = '0;
      if (!first_ok || !last_ok || first > last) begin
         r.range_error = 1'b1;
      end else if (w.cmd == CmdAdd) begin
         share = {8'd0, w.amount, 16'd0} / 64'(last - first + 1);
         for (int unsigned i = first; i <= last; i++) begin
            day_total[i] = sat_sum(day_total[i], share);
         end
      end else begin
         total = '0;
         for (int unsigned i = first; i <= last; i++) begin
            total = sat_sum(total, day_total[i]);
         end
         r.range_total = total;
      end
      predicted_rsp.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TableDepth; i++) begin
            day_total[i] = '0;
         end
         predicted_rsp.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_rsp.size() == 0) begin
               $display("%0t: unexpected response word, total %h error %b", $time,
                        rsp_mon.data.range_total, rsp_mon.data.range_error);
               mismatches++;
            end else begin
               oldest_rsp = predicted_rsp.pop_front();
               if (rsp_mon.data.range_total !== oldest_rsp.range_total) begin
                  $display("%0t: range_total mismatch, expected %h, actual %h", $time,
                           oldest_rsp.range_total, rsp_mon.data.range_total);
                  mismatches++;
               end
               if (rsp_mon.data.range_error !== oldest_rsp.range_error) begin
                  $display("%0t: range_error mismatch, expected %b, actual %b", $time,
                           oldest_rsp.range_error, rsp_mon.data.range_error);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_range_result(req_mon.data);
         end
      end
      outstanding = predicted_rsp.size();
   end

endmodule

>>> tb/tb_date_range_add_range_sum_core.sv
// ----------------------------------------------------------------------------
// tb_date_range_add_range_sum_core - testbench for the day-table accumulator
// Directed words over the calendar edges, invalid dates and reversed ranges,
// then random ranges with random idling on both sides, a long response stall
// and a full drain pause.
// Responses are checked by day_table_checker.
// ----------------------------------------------------------------------------
module tb_date_range_add_range_sum_core;
   import drs_pkg::*;
   import drs_cal_pkg::*;

   localparam int TableDepth  = TableDepthDefault;
   localparam int LastDay     = TableDepth - 1;
   localparam int RandomItems = 117;
   localparam int PauseAt     = 100;
   localparam int HoldAt      = 80;
   localparam int HoldCycles  = 500;
   localparam int DrainCycles = 100;
   localparam int CycleLimit  = 3_000_000;

   localparam logic [AmountW-1:0] AmountMax = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycle_count;
   bit   send_steady;

   always #1 clock = ~clock;

   drs_req_if req_bus ();
   drs_rsp_if rsp_bus ();

   date_range_add_range_sum_core #(
      .TABLE_DEPTH(TableDepth)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   day_table_checker #(
      .TableDepth(TableDepth)
   ) table_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // day number -> {year, month, day}; runs past the table end if asked
   function automatic logic [YearW+MonthW+DayW-1:0] date_of(int unsigned idx);
      int unsigned rest;
      int unsigned y;
      int unsigned m;
      rest = idx;
      y    = BaseYear;
      while (rest >= 365 + is_leap(y)) begin
         rest -= 365 + is_leap(y);
         y++;
      end
      m = 1;
      while (rest >= days_in(y, m)) begin
         rest -= days_in(y, m);
         m++;
      end
      return {YearW'(y), MonthW'(m), DayW'(rest + 1)};
   endfunction

   function automatic req_payload_type range_word(logic cmd, int unsigned first,
                                                  int unsigned last, logic [AmountW-1:0] amt);
      req_payload_type w;
      w.cmd = cmd;
      {w.from_year, w.from_month, w.from_day} = date_of(first);
      {w.to_year, w.to_month, w.to_day}       = date_of(last);
      w.amount = amt;
      return w;
   endfunction

   function automatic req_payload_type date_word(logic cmd,
         int unsigned fy, int unsigned fm, int unsigned fd,
         int unsigned ty, int unsigned tm, int unsigned td, logic [AmountW-1:0] amt);
      req_payload_type w;
      w.cmd        = cmd;
      w.from_year  = YearW'(fy);
      w.from_month = MonthW'(fm);
      w.from_day   = DayW'(fd);
      w.to_year    = YearW'(ty);
      w.to_month   = MonthW'(tm);
      w.to_day     = DayW'(td);
      w.amount     = amt;
      return w;
   endfunction

   // called and left at a falling edge
   task automatic send_word(input req_payload_type w);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         send_steady = !send_steady;
      end
      gap = send_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.data  = w;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // response side: random gaps, steady stretches, one long hold
   initial begin
      int gap;
      int taken;
      bit steady;
      taken = 0;
      steady = 1'b0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            steady = !steady;
         end
         gap = steady ? 0 : $urandom_range(0, 6);
         if (taken == HoldAt) begin
            gap = HoldCycles;
         end
         if (gap > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_payload_type   w;
      int unsigned       first;
      int unsigned       last;
      int unsigned       span;
      int unsigned       pick;
      logic [AmountW-1:0] amt;
      logic [95:0]       noise;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      send_steady   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // calendar edges, field extremes, bad dates, reversed ranges
      send_word(date_word(CmdAdd, 2000, 1, 1, 2000, 1, 1, AmountMax));
      send_word(date_word(CmdSum, 2000, 1, 1, 2000, 1, 1, '0));
      send_word(date_word(CmdAdd, 2000, 1, 1, 2000, 12, 31, '0));
      send_word(date_word(CmdAdd, 2000, 2, 28, 2000, 3, 1, 40'h12_3456_789A));
      send_word(date_word(CmdAdd, 2100, 2, 28, 2100, 3, 1, 40'h00_0001_0000));
      send_word(date_word(CmdSum, 2000, 2, 29, 2000, 2, 29, '0));
      send_word(date_word(CmdSum, 2000, 1, 1, 2000, 3, 31, '0));
      send_word(range_word(CmdAdd, 0, LastDay, AmountMax));
      send_word(range_word(CmdSum, 0, LastDay, '0));
      send_word(range_word(CmdSum, LastDay, LastDay, '0));
      send_word(range_word(CmdSum, 0, TableDepth, '0));
      send_word(date_word(CmdAdd, 1999, 12, 31, 2000, 1, 1, AmountMax));
      send_word(date_word(CmdSum, 2000, 1, 1, 4095, 12, 31, '0));
      send_word(date_word(CmdAdd, 2000, 0, 1, 2000, 1, 1, AmountMax));
      send_word(date_word(CmdSum, 2000, 1, 1, 2000, 13, 1, '0));
      send_word(date_word(CmdAdd, 2000, 1, 0, 2000, 1, 2, AmountMax));
      send_word(date_word(CmdSum, 2000, 4, 31, 2000, 5, 1, '0));
      send_word(date_word(CmdAdd, 2100, 2, 29, 2100, 3, 1, AmountMax));
      send_word(date_word(CmdAdd, 2000, 1, 2, 2000, 1, 1, AmountMax));
      send_word(date_word(CmdSum, 2099, 12, 31, 2000, 1, 1, '0));
      send_word(date_word(CmdAdd, 0, 0, 0, 0, 0, 0, '0));
      send_word(date_word(CmdSum, 4095, 15, 31, 4095, 15, 31, AmountMax));
      send_word(date_word(CmdSum, 2000, 1, 1, 2099, 12, 31, '0));

      // random ranges, mostly short and near the start so sums see earlier adds
      for (int k = 0; k < RandomItems; k++) begin
         if (k == PauseAt) begin
            req_bus.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         first = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1000)
                                             : $urandom_range(0, LastDay);
         pick = $urandom_range(0, 19);
         span = (pick < 14) ? $urandom_range(0, 15) :
                (pick < 19) ? $urandom_range(16, 400) : $urandom_range(401, 3000);
         last = (first + span > LastDay) ? LastDay : first + span;
         pick = $urandom_range(0, 7);
         amt  = (pick == 0) ? AmountMax :
                (pick == 1) ? AmountW'($urandom_range(0, 255)) :
                              {8'($urandom()), 32'($urandom())};
         w = range_word(1'($urandom()), first, last, amt);
         pick = $urandom_range(0, 99);
         if (pick >= 75 && pick < 85) begin
            if (first == last) begin
               if (first == 0) begin
                  last = 1;
               end else begin
                  first = first - 1;
               end
            end
            w = range_word(w.cmd, last, first, amt);
         end else if (pick >= 85) begin
            case ($urandom_range(0, 7))
               0: w.from_year = YearW'($urandom_range(0, BaseYear - 1));
               1: w.to_year = YearW'($urandom_range(2180, 4095));
               2: begin
                  pick = $urandom_range(0, 3);
                  w.from_month = (pick == 0) ? 4'd0 : MonthW'(12 + pick);
               end
               3: w.to_day = '0;
               4: w.from_day = DayW'($urandom_range(29, 31));
               default: begin
                  noise = {$urandom(), $urandom(), $urandom()};
                  w = noise[$bits(req_payload_type)-1:0];
               end
            endcase
         end
         send_word(w);
      end

      req_bus.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
